// ===== rtl/receive_ack_scoreboard_defines.svh =====
// shared assertion macros for the receive scoreboard
`ifndef RECEIVE_ACK_SCOREBOARD_DEFINES_SVH
`define RECEIVE_ACK_SCOREBOARD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RAS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scoreboard assertion failed");

// next-cycle implication, disabled in reset
`define RAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scoreboard assertion failed");

`endif

// ===== rtl/ras_pkg.sv =====
`default_nettype none
package ras_pkg;

  localparam int unsigned SEG_W    = 24;
  localparam int unsigned PKT_W    = 16;
  localparam int unsigned BASE_W   = 25;
  localparam int unsigned MSS_W    = 14;
  localparam int unsigned HDR_W    = 8;
  localparam int unsigned ACK_W    = 38;
  localparam int unsigned SACK_W   = 24;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned MARK_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_MSS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR = 2'd1;

  localparam logic [MSS_W-1:0] MSS_RESET = 14'd1460;
  localparam logic [HDR_W-1:0] HDR_RESET = 8'd40;

  typedef struct packed {
    logic [SEG_W-1:0] segment_index;
    logic [PKT_W-1:0] packet_bytes;
  } in_t;

  typedef struct packed {
    logic [ACK_W-1:0]   ack_bytes;
    logic [SACK_W-1:0]  sel_ack_bytes;
    logic               duplicate;
    logic               out_of_window;
    logic [TOTAL_W-1:0] payload_total;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLASS,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic take;
    logic rd_seg;
    logic rd_base;
    logic mark;
    logic unmark;
    logic set_dup;
    logic set_oow;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic below_base;
    logic beyond_win;
    logic rd_bit;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/ras_ctrl.sv =====
`default_nettype none
`include "receive_ack_scoreboard_defines.svh"
module ras_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire ras_pkg::sts_t sts,
  output ras_pkg::cmd_t      cmd
);

  ras_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ras_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ras_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ras_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ras_pkg::ST_IDLE;
        end
      end
      ras_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ras_pkg::ST_CLASS;
        end
      end
      ras_pkg::ST_CLASS: begin
        priority if (sts.below_base) begin
          cmd.set_dup = 1'b1;
          state_nxt   = ras_pkg::ST_MUL;
        end else if (sts.beyond_win) begin
          cmd.set_oow = 1'b1;
          state_nxt   = ras_pkg::ST_MUL;
        end else begin
          cmd.rd_seg = 1'b1;
          state_nxt  = ras_pkg::ST_CHECK;
        end
      end
      ras_pkg::ST_CHECK: begin
        if (sts.rd_bit) begin
          cmd.set_dup = 1'b1;
          state_nxt   = ras_pkg::ST_MUL;
        end else begin
          cmd.mark  = 1'b1;
          state_nxt = ras_pkg::ST_SCAN;
        end
      end
      ras_pkg::ST_SCAN: begin
        cmd.rd_base = 1'b1;
        state_nxt   = ras_pkg::ST_SCAN_CHK;
      end
      ras_pkg::ST_SCAN_CHK: begin
        // walk the leading run of received segments
        if (sts.rd_bit) begin
          cmd.unmark = 1'b1;
          state_nxt  = ras_pkg::ST_SCAN;
        end else begin
          state_nxt = ras_pkg::ST_MUL;
        end
      end
      ras_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ras_pkg::ST_OUT;
      end
      ras_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ras_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ras_pkg::ST_CLEAR;
      end
    endcase
  end

  `RAS_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_r)
  `RAS_ASSERT_IMPL(a_out_held_while_busy, out_valid_r && out_stall && state_r != ras_pkg::ST_OUT,
                   !cmd.load_out)
  `RAS_ASSERT_NEXT(a_take_goes_class, cmd.take, state_r == ras_pkg::ST_CLASS)

endmodule
`default_nettype wire

// ===== rtl/ras_datapath.sv =====
`default_nettype none
`include "receive_ack_scoreboard_defines.svh"
module ras_datapath #(
  parameter int unsigned WINDOW_SEGMENTS = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ras_pkg::in_t                      in_data,
  output ras_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [ras_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ras_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  wire ras_pkg::cmd_t                     cmd,
  output ras_pkg::sts_t                          sts
);

  localparam int unsigned AW = (WINDOW_SEGMENTS > 1) ? $clog2(WINDOW_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(WINDOW_SEGMENTS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_SEGMENTS - 1);
  localparam logic [AW:0]   WIN_SLOTS = (AW + 1)'(WINDOW_SEGMENTS);
  localparam logic [ras_pkg::BASE_W-1:0] WIN_SEGS = ras_pkg::BASE_W'(WINDOW_SEGMENTS);
  localparam logic [CW-1:0] WIN_CNT = CW'(WINDOW_SEGMENTS);
  localparam int unsigned ACKP_W  = ras_pkg::BASE_W + ras_pkg::MSS_W;
  localparam int unsigned SACKP_W = ras_pkg::MARK_W + ras_pkg::MSS_W;
  localparam logic [ras_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [ras_pkg::SACK_W-1:0]  SACK_MAX  = '1;

  logic                         mem [WINDOW_SEGMENTS];
  logic                         rd_bit_r;
  logic [AW-1:0]                clr_idx_r;
  logic [ras_pkg::MSS_W-1:0]    mss_r;
  logic [ras_pkg::HDR_W-1:0]    hdr_r;
  logic [ras_pkg::SEG_W-1:0]    seg_r;
  logic [ras_pkg::PKT_W-1:0]    pkt_r;
  logic [ras_pkg::BASE_W-1:0]   base_r;
  logic [AW-1:0]                base_slot_r;
  logic [CW-1:0]                marked_r;
  logic [ras_pkg::TOTAL_W-1:0]  total_r;
  logic                         dup_r, oow_r;
  logic [ACKP_W-1:0]            ack_prod_r;
  logic [SACKP_W-1:0]           sack_prod_r;
  ras_pkg::out_t                out_r;

  logic [ras_pkg::BASE_W-1:0]   diff;
  logic [AW:0]                  slot_sum;
  logic [AW-1:0]                seg_slot;
  logic [ras_pkg::PKT_W-1:0]    pay;
  logic [ras_pkg::TOTAL_W:0]    total_sum;
  logic                         mem_we, mem_wd;
  logic [AW-1:0]                mem_wa, mem_ra;

  // ring slot of the segment, relative to the slot of the cumulative point
  assign diff     = {1'b0, seg_r} - base_r;
  assign slot_sum = {1'b0, base_slot_r} + {1'b0, diff[AW-1:0]};
  assign seg_slot = (slot_sum >= WIN_SLOTS) ? AW'(slot_sum - WIN_SLOTS) : slot_sum[AW-1:0];

  assign sts.clr_last   = (clr_idx_r == LAST_SLOT);
  assign sts.below_base = ({1'b0, seg_r} < base_r);
  assign sts.beyond_win = (diff >= WIN_SEGS);
  assign sts.rd_bit     = rd_bit_r;

  assign pay       = (pkt_r > {8'd0, hdr_r}) ? (pkt_r - {8'd0, hdr_r}) : '0;
  assign total_sum = {1'b0, total_r} + {{(ras_pkg::TOTAL_W + 1 - ras_pkg::PKT_W){1'b0}}, pay};

  always_comb begin
    mem_we = 1'b0;
    mem_wd = 1'b0;
    mem_wa = seg_slot;
    priority if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
    end else if (cmd.mark) begin
      mem_we = 1'b1;
      mem_wd = 1'b1;
      mem_wa = seg_slot;
    end else if (cmd.unmark) begin
      mem_we = 1'b1;
      mem_wa = base_slot_r;
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_ra = cmd.rd_base ? base_slot_r : seg_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_seg || cmd.rd_base) begin
      rd_bit_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      mss_r       <= ras_pkg::MSS_RESET;
      hdr_r       <= ras_pkg::HDR_RESET;
      base_r      <= '0;
      base_slot_r <= '0;
      marked_r    <= '0;
      total_r     <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == ras_pkg::REG_MSS) begin
          mss_r <= cfg_wdata;
        end else if (cfg_index == ras_pkg::REG_HDR) begin
          hdr_r <= cfg_wdata[ras_pkg::HDR_W-1:0];
        end
      end
      if (cmd.mark) begin
        marked_r <= marked_r + 1'b1;
        total_r  <= total_sum[ras_pkg::TOTAL_W] ? TOTAL_MAX : total_sum[ras_pkg::TOTAL_W-1:0];
      end
      if (cmd.unmark) begin
        marked_r    <= marked_r - 1'b1;
        base_r      <= base_r + 1'b1;
        base_slot_r <= (base_slot_r == LAST_SLOT) ? '0 : base_slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      seg_r <= in_data.segment_index;
      pkt_r <= in_data.packet_bytes;
      dup_r <= 1'b0;
      oow_r <= 1'b0;
    end
    if (cmd.set_dup) begin
      dup_r <= 1'b1;
    end
    if (cmd.set_oow) begin
      oow_r <= 1'b1;
    end
    if (cmd.mul) begin
      ack_prod_r  <= base_r * mss_r;
      sack_prod_r <= ras_pkg::MARK_W'(marked_r) * mss_r;
    end
    if (cmd.load_out) begin
      out_r.ack_bytes     <= ack_prod_r[ras_pkg::ACK_W-1:0];
      out_r.sel_ack_bytes <= (sack_prod_r > SACKP_W'(SACK_MAX)) ? SACK_MAX
                                                               : sack_prod_r[ras_pkg::SACK_W-1:0];
      out_r.duplicate     <= dup_r;
      out_r.out_of_window <= oow_r;
      out_r.payload_total <= total_r;
    end
  end

  assign out_data = out_r;

  `RAS_ASSERT_IMPL(a_marked_in_window, 1'b1, marked_r <= WIN_CNT)
  `RAS_ASSERT_IMPL(a_unmark_only_set, cmd.unmark, rd_bit_r)
  `RAS_ASSERT_NEXT(a_advance_counts, cmd.unmark, base_r == $past(base_r) + 1'b1)

endmodule
`default_nettype wire

// ===== rtl/receive_ack_scoreboard.sv =====
`default_nettype none
// Receive scoreboard for one flow. Each request is an arriving segment (index and
// packet length); each gives exactly one result with the cumulative ack and
// selective-ack count in bytes, duplicate and out-of-window flags and the
// saturating payload total. The input is stalled from taking an item until its
// result is loaded. An item below the cumulative point or outside the window goes
// from classification straight to the multiply and output states; a duplicate
// inside the window first passes a bitmap check; a new one is marked, and then the
// cumulative point advances over the leading run of received segments: the bitmap
// read is registered, so each step of that walk has a read state and a check state.
// The result is loaded in the output state; while an earlier result is still
// stalled at the output the item waits there. After reset a clearing pass sweeps
// every bitmap slot before the first request is taken; configuration writes are
// accepted during it. Registers: index 0 segment size, index 1 header length.
module receive_ack_scoreboard #(
  parameter int unsigned WINDOW_SEGMENTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ras_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ras_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [ras_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ras_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  ras_pkg::cmd_t cmd;
  ras_pkg::sts_t sts;

  ras_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ras_datapath #(
    .WINDOW_SEGMENTS (WINDOW_SEGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
